// ===== sv/rgbpk_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB pixel format packer package
// Shared request types, register indexes and pixel format codes for the
// remote-framebuffer pixel packer.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbpk_pkg;

    // Source pixel request.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } pixel_in_t;

    // Packed pixel result.
    typedef struct packed {
        logic [31:0] pixel_bytes;
        logic [2:0]  byte_count;
        logic        rect_end;
    } pixel_out_t;

    // Configuration register indexes (word address).
    typedef enum logic [2:0] {
        REG_BPP        = 3'd0,
        REG_BIG_ENDIAN = 3'd1,
        REG_RED_WIDTH  = 3'd2,
        REG_GRN_WIDTH  = 3'd3,
        REG_BLU_WIDTH  = 3'd4,
        REG_RED_POS    = 3'd5,
        REG_GRN_POS    = 3'd6,
        REG_BLU_POS    = 3'd7
    } reg_idx_t;

    // Supported client pixel sizes.
    localparam logic [7:0] BPP_32 = 8'd32;
    localparam logic [7:0] BPP_24 = 8'd24;
    localparam logic [7:0] BPP_16 = 8'd16;
    localparam logic [7:0] BPP_15 = 8'd15;
    localparam logic [7:0] BPP_8  = 8'd8;

    // Byte counts reported with each result.
    localparam logic [2:0] CNT_NONE  = 3'd0;
    localparam logic [2:0] CNT_ONE   = 3'd1;
    localparam logic [2:0] CNT_TWO   = 3'd2;
    localparam logic [2:0] CNT_THREE = 3'd3;
    localparam logic [2:0] CNT_FOUR  = 3'd4;

    // Channel width limit and pad byte.
    localparam logic [3:0] CHAN_BITS = 4'd8;
    localparam logic [7:0] PAD_BYTE  = 8'hFF;

    // Reset values of the registers.
    localparam logic [7:0] RST_BPP   = BPP_32;
    localparam logic [3:0] RST_WIDTH = 4'd8;

endpackage

`default_nettype wire

// ===== sv/rgb_pixel_format_packer_top.sv =====
// An accepted pixel request moves through stages 1, 2 and 3 to its result.
// Throughput: one pixel per cycle; the three register stages each hold one
// pixel and advance together unless the result side stalls.
// Reset: rst_n clears the stage valid bits and loads the registers with
// 32 bpp, little-endian order, 8-bit channels at position zero.
// ----------------------------------------------------------------------------
// RGB pixel format packer
// Packs 8-bit-per-channel RGB pixels into the client's remote-framebuffer
// pixel format: truncate, shift and merge (16/15/8 bpp), then order the bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_pixel_format_packer_top
    import rgbpk_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Pixel input channel
    input  wire logic        pix_valid,
    output logic             pix_ready,
    input  wire pixel_in_t   pix_data,
    // Result channel
    output logic             res_valid,
    input  wire logic        res_ready,
    output pixel_out_t       res_data,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] bpp_reg;
    logic       big_endian_reg;
    logic [3:0] red_width_reg;
    logic [3:0] grn_width_reg;
    logic [3:0] blu_width_reg;
    logic [3:0] red_pos_reg;
    logic [3:0] grn_pos_reg;
    logic [3:0] blu_pos_reg;

    logic       cfg_write;
    reg_idx_t   cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[4:2]);

    // Register write at the access phase of a write request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg        <= RST_BPP;
            big_endian_reg <= 1'b0;
            red_width_reg  <= RST_WIDTH;
            grn_width_reg  <= RST_WIDTH;
            blu_width_reg  <= RST_WIDTH;
            red_pos_reg    <= 4'd0;
            grn_pos_reg    <= 4'd0;
            blu_pos_reg    <= 4'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_BPP:        bpp_reg        <= pwdata[7:0];
                REG_BIG_ENDIAN: big_endian_reg <= pwdata[0];
                REG_RED_WIDTH:  red_width_reg  <= pwdata[3:0];
                REG_GRN_WIDTH:  grn_width_reg  <= pwdata[3:0];
                REG_BLU_WIDTH:  blu_width_reg  <= pwdata[3:0];
                REG_RED_POS:    red_pos_reg    <= pwdata[3:0];
                REG_GRN_POS:    grn_pos_reg    <= pwdata[3:0];
                REG_BLU_POS:    blu_pos_reg    <= pwdata[3:0];
                default:        bpp_reg        <= bpp_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_BPP:        prdata[7:0] = bpp_reg;
            REG_BIG_ENDIAN: prdata[0]   = big_endian_reg;
            REG_RED_WIDTH:  prdata[3:0] = red_width_reg;
            REG_GRN_WIDTH:  prdata[3:0] = grn_width_reg;
            REG_BLU_WIDTH:  prdata[3:0] = blu_width_reg;
            REG_RED_POS:    prdata[3:0] = red_pos_reg;
            REG_GRN_POS:    prdata[3:0] = grn_pos_reg;
            REG_BLU_POS:    prdata[3:0] = blu_pos_reg;
            default:        prdata      = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or its
    // contents move on in the same cycle.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_ready, s2_ready, s3_ready;

    assign s3_ready  = !s3_valid_reg || res_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pix_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= pix_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: keep the top bits of each channel.
    // ------------------------------------------------------------------
    function automatic logic [7:0] keep_top(input logic [7:0] chan, input logic [3:0] width);
        logic [3:0] sat;
        logic [3:0] drop;
        sat  = (width > CHAN_BITS) ? CHAN_BITS : width;
        drop = CHAN_BITS - sat;
        return chan >> drop;
    endfunction

    pixel_in_t  s1_pix_reg;
    logic [7:0] s1_red_next, s1_grn_next, s1_blu_next;
    logic [7:0] s1_red_reg, s1_grn_reg, s1_blu_reg;

    assign s1_red_next = keep_top(pix_data.red,   red_width_reg);
    assign s1_grn_next = keep_top(pix_data.green, grn_width_reg);
    assign s1_blu_next = keep_top(pix_data.blue,  blu_width_reg);

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_pix_reg <= pix_data;
            s1_red_reg <= s1_red_next;
            s1_grn_reg <= s1_grn_next;
            s1_blu_reg <= s1_blu_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: shift the kept bits into place and merge; only the low
    // 16 bits of the packed word are ever sent.
    // ------------------------------------------------------------------
    pixel_in_t   s2_pix_reg;
    logic [15:0] s2_word_next;
    logic [15:0] s2_word_reg;

    assign s2_word_next = ({8'd0, s1_red_reg} << red_pos_reg)
                        | ({8'd0, s1_grn_reg} << grn_pos_reg)
                        | ({8'd0, s1_blu_reg} << blu_pos_reg);

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_pix_reg  <= s1_pix_reg;
            s2_word_reg <= s2_word_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: order the bytes for the selected pixel size.
    // ------------------------------------------------------------------
    pixel_out_t s3_out_next;
    pixel_out_t s3_out_reg;
    logic [23:0] rgb_bytes;

    assign rgb_bytes = big_endian_reg
                     ? {s2_pix_reg.blue, s2_pix_reg.green, s2_pix_reg.red}
                     : {s2_pix_reg.red,  s2_pix_reg.green, s2_pix_reg.blue};

    always_comb
    begin
        s3_out_next.pixel_bytes = '0;
        s3_out_next.byte_count  = CNT_NONE;
        s3_out_next.rect_end    = s2_pix_reg.last_pixel;
        case (bpp_reg) inside
            BPP_32:
            begin
                s3_out_next.pixel_bytes = {PAD_BYTE, rgb_bytes};
                s3_out_next.byte_count  = CNT_FOUR;
            end
            BPP_24:
            begin
                s3_out_next.pixel_bytes = {8'd0, rgb_bytes};
                s3_out_next.byte_count  = CNT_THREE;
            end
            BPP_16, BPP_15:
            begin
                s3_out_next.pixel_bytes = big_endian_reg
                    ? {16'd0, s2_word_reg[7:0], s2_word_reg[15:8]}
                    : {16'd0, s2_word_reg};
                s3_out_next.byte_count  = CNT_TWO;
            end
            BPP_8:
            begin
                s3_out_next.pixel_bytes = {24'd0, s2_word_reg[7:0]};
                s3_out_next.byte_count  = CNT_ONE;
            end
            default:
            begin
                s3_out_next.pixel_bytes = '0;
                s3_out_next.byte_count  = CNT_NONE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_out_reg <= s3_out_next;
        end
    end

    assign res_valid = s3_valid_reg;
    assign res_data  = s3_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef NO_ASSERTIONS
    // A pixel held in stage 2 while stage 3 is blocked is not dropped.
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s3_ready) |=> (s2_valid_reg && $stable(s2_word_reg)))
        else $error("stage 2 pixel lost during stall");

    // With every stage full and the result blocked, no new pixel enters.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && s3_valid_reg && !res_ready) |-> !pix_ready)
        else $error("pixel accepted into a full pipeline");

    // An unsupported pixel size sends no bytes.
    a_zero_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.byte_count == CNT_NONE) |-> (res_data.pixel_bytes == '0))
        else $error("bytes present with a zero byte count");

    // Short formats leave the unused upper bytes clear.
    a_short_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_data.byte_count == CNT_ONE || res_data.byte_count == CNT_TWO))
        |-> (res_data.pixel_bytes[31:16] == '0))
        else $error("upper bytes set in a short pixel");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_rgb_pixel_format_packer_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the RGB pixel format packer
// A short table of directed pixels, with hand-computed results at reset and
// at the extremes, is followed by phases of random pixels under random
// client pixel formats. Accepted requests with no hand-computed result are
// packed by a local model; results are checked in order, field by field.
// ----------------------------------------------------------------------------

module tb_rgb_pixel_format_packer_top;

    import rgbpk_pkg::*;

    localparam int unsigned PIPE_LATENCY   = 3;
    localparam int unsigned RANDOM_PIXELS  = 1950;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned REPORT_LIMIT   = 10;

    // Local copy of the client pixel format registers.
    typedef struct packed {
        logic [7:0] bpp;
        logic       big_end;
        logic [3:0] red_w;
        logic [3:0] grn_w;
        logic [3:0] blu_w;
        logic [3:0] red_p;
        logic [3:0] grn_p;
        logic [3:0] blu_p;
    } pix_format_t;

    localparam pix_format_t RESET_FORMAT = '{BPP_32, 1'b0, RST_WIDTH, RST_WIDTH, RST_WIDTH,
                                             4'd0, 4'd0, 4'd0};

    // One row of the directed table; known marks a hand-computed result.
    typedef struct {
        pix_format_t fmt;
        pixel_in_t   px;
        bit          known;
        pixel_out_t  want;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        pix_valid;
    logic        pix_ready;
    pixel_in_t   pix_data;
    logic        res_valid;
    logic        res_ready;
    pixel_out_t  res_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Hand-computed result that travels with the current pixel request.
    logic        pix_known;
    pixel_out_t  pix_want;

    pix_format_t   cur_format = RESET_FORMAT;
    pixel_out_t    packed_due[$];
    directed_row_t directed_rows[$];
    bit            no_idle = 1'b0;
    int unsigned   mismatches = 0;
    int unsigned   pixels_sent = 0;
    int unsigned   results_seen = 0;
    int unsigned   formats_used = 0;
    int unsigned   quiet_cycles = 0;

    rgb_pixel_format_packer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #2 clk = ~clk;

    // Keep the top bits of a channel and move them to their position.
    function automatic logic [31:0] keep_msbs(logic [7:0] chan, logic [3:0] width,
                                              logic [3:0] pos);
        logic [31:0] kept;
        int unsigned w;
        w = (width > CHAN_BITS) ? CHAN_BITS : width;
        kept = {24'h0, chan} >> (8 - w);
        return kept << pos;
    endfunction

    // Pack one pixel under the given format.
    function automatic pixel_out_t pack_pixel(pixel_in_t px, pix_format_t f);
        pixel_out_t  o;
        logic [31:0] word;
        logic [7:0]  hi;
        logic [7:0]  lo;
        o.pixel_bytes = '0;
        o.byte_count  = CNT_NONE;
        o.rect_end    = px.last_pixel;
        if (f.bpp == BPP_32 || f.bpp == BPP_24)
        begin
            if (f.big_end)
                o.pixel_bytes = {8'h00, px.blue, px.green, px.red};
            else
                o.pixel_bytes = {8'h00, px.red, px.green, px.blue};
            o.byte_count = CNT_THREE;
            if (f.bpp == BPP_32)
            begin
                o.pixel_bytes[31:24] = PAD_BYTE;
                o.byte_count = CNT_FOUR;
            end
        end
        else if (f.bpp == BPP_16 || f.bpp == BPP_15 || f.bpp == BPP_8)
        begin
            word = keep_msbs(px.red, f.red_w, f.red_p) |
                   keep_msbs(px.green, f.grn_w, f.grn_p) |
                   keep_msbs(px.blue, f.blu_w, f.blu_p);
            hi = word[15:8];
            lo = word[7:0];
            if (f.bpp == BPP_8)
            begin
                o.pixel_bytes = {24'h0, lo};
                o.byte_count = CNT_ONE;
            end
            else
            begin
                o.pixel_bytes = f.big_end ? {16'h0, lo, hi} : {16'h0, hi, lo};
                o.byte_count = CNT_TWO;
            end
        end
        return o;
    endfunction

    function automatic pix_format_t make_format(logic [7:0] bpp, logic be,
                                                logic [3:0] rw, logic [3:0] gw,
                                                logic [3:0] bw, logic [3:0] rp,
                                                logic [3:0] gp, logic [3:0] bp);
        return '{bpp, be, rw, gw, bw, rp, gp, bp};
    endfunction

    // Mostly short gaps, a few long ones, none while a burst phase runs.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [3:0] random_width();
        if ($urandom_range(0, 99) < 85)
            return 4'($urandom_range(1, 8));
        return 4'($urandom_range(0, 15));
    endfunction

    // Random client format: mostly supported sizes, some odd ones.
    function automatic pix_format_t random_format();
        pix_format_t f;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 4)
            f.bpp = BPP_32;
        else if (pick < 7)
            f.bpp = BPP_24;
        else if (pick < 11)
            f.bpp = BPP_16;
        else if (pick < 14)
            f.bpp = BPP_15;
        else if (pick < 17)
            f.bpp = BPP_8;
        else if (pick == 17)
            f.bpp = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        else
            f.bpp = 8'($urandom_range(0, 255));
        f.big_end = 1'($urandom_range(0, 1));
        f.red_w = random_width();
        f.grn_w = random_width();
        f.blu_w = random_width();
        if ($urandom_range(0, 1))
        begin
            // Fields laid next to each other, blue at the bottom.
            f.blu_p = 4'd0;
            f.grn_p = f.blu_w;
            f.red_p = f.blu_w + f.grn_w;
        end
        else
        begin
            f.red_p = 4'($urandom_range(0, 15));
            f.grn_p = 4'($urandom_range(0, 15));
            f.blu_p = 4'($urandom_range(0, 15));
        end
        return f;
    endfunction

    function automatic void report_mismatch(string what, logic [31:0] want,
                                            logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
    endfunction

    function automatic void add_row(pix_format_t f, logic [7:0] r, logic [7:0] g,
                                    logic [7:0] b, logic last, bit known,
                                    logic [31:0] bytes, logic [2:0] count);
        directed_row_t row;
        row.fmt   = f;
        row.px    = '{r, g, b, last};
        row.known = known;
        row.want  = '{bytes, count, last};
        directed_rows = {directed_rows, row};
    endfunction

    // Directed pixels: reset format, every pixel size, both byte orders,
    // zero and oversized channel widths, packed words wider than the pixel.
    function automatic void build_directed_table();
        pix_format_t f;
        add_row(RESET_FORMAT, 8'h12, 8'h34, 8'h56, 1'b0, 1, 32'hFF123456, CNT_FOUR);
        add_row(RESET_FORMAT, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1, 32'hFFFFFFFF, CNT_FOUR);
        add_row(RESET_FORMAT, 8'h00, 8'h00, 8'h00, 1'b0, 1, 32'hFF000000, CNT_FOUR);
        f = make_format(BPP_32, 1'b1, 4'd8, 4'd8, 4'd8, 4'd0, 4'd0, 4'd0);
        add_row(f, 8'h12, 8'h34, 8'h56, 1'b0, 1, 32'hFF563412, CNT_FOUR);
        f = make_format(BPP_24, 1'b0, 4'd8, 4'd8, 4'd8, 4'd0, 4'd0, 4'd0);
        add_row(f, 8'h12, 8'h34, 8'h56, 1'b0, 1, 32'h00123456, CNT_THREE);
        f.big_end = 1'b1;
        add_row(f, 8'hFF, 8'h00, 8'h80, 1'b1, 0, '0, CNT_NONE);
        f = make_format(BPP_16, 1'b0, 4'd5, 4'd6, 4'd5, 4'd11, 4'd5, 4'd0);
        add_row(f, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1, 32'h0000FFFF, CNT_TWO);
        add_row(f, 8'h12, 8'h34, 8'h56, 1'b1, 0, '0, CNT_NONE);
        f.big_end = 1'b1;
        add_row(f, 8'hA5, 8'h5A, 8'hC3, 1'b0, 0, '0, CNT_NONE);
        f = make_format(BPP_15, 1'b0, 4'd5, 4'd5, 4'd5, 4'd10, 4'd5, 4'd0);
        add_row(f, 8'hFF, 8'h00, 8'hFF, 1'b0, 0, '0, CNT_NONE);
        f.big_end = 1'b1;
        add_row(f, 8'h7E, 8'h81, 8'h3C, 1'b1, 0, '0, CNT_NONE);
        f = make_format(BPP_8, 1'b0, 4'd3, 4'd3, 4'd2, 4'd5, 4'd2, 4'd0);
        add_row(f, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1, 32'h000000FF, CNT_ONE);
        add_row(f, 8'h80, 8'h40, 8'hC0, 1'b1, 0, '0, CNT_NONE);
        // Unsupported pixel sizes send nothing.
        f = make_format(8'd0, 1'b0, 4'd8, 4'd8, 4'd8, 4'd0, 4'd0, 4'd0);
        add_row(f, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1, 32'h0, CNT_NONE);
        f.bpp = 8'd255;
        add_row(f, 8'h12, 8'h34, 8'h56, 1'b0, 1, 32'h0, CNT_NONE);
        f = make_format(8'd7, 1'b1, 4'd5, 4'd6, 4'd5, 4'd11, 4'd5, 4'd0);
        add_row(f, 8'hAA, 8'h55, 8'hAA, 1'b0, 1, 32'h0, CNT_NONE);
        // Zero-width channels leave an empty word.
        f = make_format(BPP_16, 1'b0, 4'd0, 4'd0, 4'd0, 4'd3, 4'd7, 4'd15);
        add_row(f, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1, 32'h0, CNT_TWO);
        // Widths above eight keep the whole channel.
        f = make_format(BPP_16, 1'b1, 4'd15, 4'd9, 4'd12, 4'd8, 4'd4, 4'd0);
        add_row(f, 8'hC3, 8'h5A, 8'h96, 1'b1, 0, '0, CNT_NONE);
        // Packed word spills past the pixel size.
        f = make_format(BPP_8, 1'b1, 4'd8, 4'd8, 4'd8, 4'd15, 4'd8, 4'd12);
        add_row(f, 8'hFF, 8'h01, 8'h80, 1'b0, 0, '0, CNT_NONE);
        f = make_format(BPP_16, 1'b0, 4'd8, 4'd8, 4'd8, 4'd15, 4'd15, 4'd15);
        add_row(f, 8'h01, 8'hFF, 8'h00, 1'b1, 0, '0, CNT_NONE);
        f.bpp = BPP_15;
        add_row(f, 8'hFF, 8'h00, 8'h01, 1'b0, 0, '0, CNT_NONE);
    endfunction

    // Register write: setup cycle, then access until pready is seen.
    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (!pready);
        @(posedge clk);
    endtask

    task automatic program_format(pix_format_t f);
        write_reg(REG_BPP,        {24'h0, f.bpp});
        write_reg(REG_BIG_ENDIAN, {31'h0, f.big_end});
        write_reg(REG_RED_WIDTH,  {28'h0, f.red_w});
        write_reg(REG_GRN_WIDTH,  {28'h0, f.grn_w});
        write_reg(REG_BLU_WIDTH,  {28'h0, f.blu_w});
        write_reg(REG_RED_POS,    {28'h0, f.red_p});
        write_reg(REG_GRN_POS,    {28'h0, f.grn_p});
        write_reg(REG_BLU_POS,    {28'h0, f.blu_p});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_format = f;
        formats_used++;
    endtask

    // Let every pending result drain and the pipeline settle.
    task automatic wait_drained();
        pix_valid <= 1'b0;
        while (packed_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 1) @(posedge clk);
    endtask

    // Present one pixel request and hold it until it is taken.
    task automatic send_pixel(pixel_in_t px, bit known, pixel_out_t want);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= px;
        pix_known <= known;
        pix_want  <= want;
        do
            @(negedge clk);
        while (!pix_ready);
        @(posedge clk);
    endtask

    // Result side: random stalls, occasionally long open stretches.
    initial
    begin : result_sink
        int unsigned hold;
        int unsigned open_run;
        res_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = pick_gap();
            if (hold != 0)
            begin
                res_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            res_ready <= 1'b1;
            open_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 24);
            repeat (open_run) @(posedge clk);
        end
    end

    // Handshakes are judged at the falling edge, where every signal is
    // stable for the rising edge that follows.
    always @(negedge clk)
    begin : scoreboard
        pixel_out_t want;
        bit         moved;
        moved = 1'b0;
        if (rst_n)
        begin
            // Record the expected result of an accepted pixel request.
            if (pix_valid && pix_ready)
            begin
                packed_due = {packed_due,
                              (pix_known ? pix_want : pack_pixel(pix_data, cur_format))};
                pixels_sent++;
                moved = 1'b1;
            end
            // Compare an accepted result request with the oldest expectation.
            if (res_valid && res_ready)
            begin
                results_seen++;
                moved = 1'b1;
                if (packed_due.size() == 0)
                    report_mismatch("unexpected result", '0, res_data.pixel_bytes);
                else
                begin
                    want = packed_due.pop_front();
                    if (res_data.pixel_bytes !== want.pixel_bytes)
                        report_mismatch("pixel_bytes", want.pixel_bytes,
                                        res_data.pixel_bytes);
                    if (res_data.byte_count !== want.byte_count)
                        report_mismatch("byte_count", {29'h0, want.byte_count},
                                        {29'h0, res_data.byte_count});
                    if (res_data.rect_end !== want.rect_end)
                        report_mismatch("rect_end", {31'h0, want.rect_end},
                                        {31'h0, res_data.rect_end});
                end
            end
            if (psel && penable && pwrite && pready)
                moved = 1'b1;
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            // Watchdog on a stalled run.
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: %0d cycles without a transfer", quiet_cycles);
                $display("tb_rgb_pixel_format_packer_top failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        directed_row_t row;
        pixel_in_t     px;
        int unsigned   random_sent;
        int unsigned   phase_len;
        rst_n     <= 1'b0;
        pix_valid <= 1'b0;
        pix_data  <= '0;
        pix_known <= 1'b0;
        pix_want  <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        random_sent = 0;
        build_directed_table();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; the format is reprogrammed only where it changes.
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.fmt != cur_format)
            begin
                wait_drained();
                program_format(row.fmt);
            end
            send_pixel(row.px, row.known, row.want);
        end

        // Random phases, each under a fresh format.
        while (random_sent < RANDOM_PIXELS)
        begin
            wait_drained();
            program_format(random_format());
            no_idle = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(1, 80);
            if (phase_len > RANDOM_PIXELS - random_sent)
                phase_len = RANDOM_PIXELS - random_sent;
            repeat (phase_len)
            begin
                px.red        = 8'($urandom_range(0, 255));
                px.green      = 8'($urandom_range(0, 255));
                px.blue       = 8'($urandom_range(0, 255));
                px.last_pixel = ($urandom_range(0, 7) == 0);
                send_pixel(px, 1'b0, '0);
                random_sent++;
            end
        end
        no_idle = 1'b0;
        wait_drained();

        if (packed_due.size() != 0)
            report_mismatch("missing results", '0, packed_due.size());
        $display("Sent %0d pixels (%0d directed) under %0d programmed formats.",
                 pixels_sent, directed_rows.size(), formats_used);
        $display("Checked %0d packed results, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0)
            $display("tb_rgb_pixel_format_packer_top passed");
        else
            $display("tb_rgb_pixel_format_packer_top failed");
        $finish;
    end

endmodule
